[rtl/rau_pkg.sv]
package rau_pkg;

    localparam int OperandWidthDefault = 16;
    localparam int ResNumWidth         = 32;
    localparam int ResDenWidth         = 31;
    localparam int CmdWidth            = 3;

    typedef enum logic [CmdWidth-1:0] {
        CMD_ADD   = 3'd0,
        CMD_SUB   = 3'd1,
        CMD_MUL   = 3'd2,
        CMD_DIV   = 3'd3,
        CMD_CMP   = 3'd4,
        CMD_SIMP  = 3'd5,
        CMD_RECIP = 3'd6,
        CMD_NONE  = 3'd7
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_GCD_DIV,
        ST_GCD_STEP,
        ST_QA_DIV,
        ST_L_MUL,
        ST_PA_DIV,
        ST_PA_MUL,
        ST_PB_DIV,
        ST_PB_MUL,
        ST_M1_MUL,
        ST_M2_MUL,
        ST_SN_DIV,
        ST_SD_DIV,
        ST_FINISH,
        ST_OUT
    } state_t;

endpackage

[rtl/rau_if.sv]
interface rau_in_if #(parameter int W = rau_pkg::OperandWidthDefault);
    logic                      valid;
    logic                      ready;
    logic [rau_pkg::CmdWidth-1:0] cmd;
    logic signed [W-1:0]       num_a;
    logic [W-2:0]              den_a;
    logic signed [W-1:0]       num_b;
    logic [W-2:0]              den_b;

    modport source (output valid, cmd, num_a, den_a, num_b, den_b, input ready);
    modport sink   (input valid, cmd, num_a, den_a, num_b, den_b, output ready);
endinterface

interface rau_out_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [rau_pkg::ResNumWidth-1:0] res_num;
    logic [rau_pkg::ResDenWidth-1:0]        res_den;
    logic                                   greater;
    logic                                   less;
    logic                                   equal;
    logic                                   zero_den_error;

    modport source (output valid, res_num, res_den, greater, less, equal, zero_den_error,
                    input ready);
    modport sink   (input valid, res_num, res_den, greater, less, equal, zero_den_error,
                    output ready);
endinterface

[rtl/rational_arithmetic_unit.sv]
// channel | dir | handshake   | payload
// in      | in  | valid/ready | cmd, num_a, den_a, num_b, den_b
// out     | out | valid/ready | res_num, res_den, greater, less, equal, zero_den_error
// one item at a time; a bit-serial shift-subtract divider and a shift-add
// multiplier do all the work
// add/sub: gcd (up to about 1.5*W steps) + 6 serial ops; mul/cmp/div:
// 2 ops; simplify: gcd + 2 ops; reciprocal and division by zero: none
// plus the setup, output and idle states, and a combine step for add/sub/mul/div/cmp
// reset clears control only; out holds its item until ready, in is stalled meanwhile
module rational_arithmetic_unit #(
    parameter int OPERAND_WIDTH = rau_pkg::OperandWidthDefault
) (
    input  logic     clk,
    input  logic     rst_n,
    rau_in_if.sink   in_ch,
    rau_out_if.source out_ch
);
    import rau_pkg::*;

    localparam int W  = OPERAND_WIDTH;
    // working width: products of two W-bit magnitudes
    localparam int XW = 2 * W + 2;
    localparam int CW = $clog2(XW + 1);
    // saturation compare width: at least the 33 bits of the signed limits
    localparam int SW = (XW + 1 > 33) ? XW + 1 : 33;

    state_t state_reg, state_next;
    cmd_t   cmd_reg;
    logic signed [W-1:0] na_reg, nb_reg;
    logic [W-2:0]        da_reg, db_reg;

    // serial unit registers
    logic [XW-1:0] acc_reg;    // remainder or product
    logic [XW-1:0] opa_reg;    // dividend or multiplicand (shifted)
    logic [XW-1:0] opb_reg;    // divisor or multiplier (shifted)
    logic [XW-1:0] quo_reg;
    logic [CW-1:0] cnt_reg;

    // gcd and intermediate values
    logic [W-1:0]  gx_reg, gy_reg;
    logic [XW-1:0] l_reg, pa_reg, t_reg;
    logic signed [XW:0] rn_reg;
    logic [XW-1:0] rd_reg;
    logic          gt_reg, lt_reg, eq_reg, err_reg;

    logic [XW-1:0] abs_na, abs_nb;
    logic          in_fire, out_fire, unit_done;
    logic [XW:0]   trial;
    logic          result_ready;
    logic signed [SW-1:0] rn_wide;
    logic [SW-1:0]        rd_wide;

    assign abs_na = XW'(na_reg[W-1] ? -{{(XW-W){1'b1}}, na_reg} : {{(XW-W){1'b0}}, na_reg});
    assign abs_nb = XW'(nb_reg[W-1] ? -{{(XW-W){1'b1}}, nb_reg} : {{(XW-W){1'b0}}, nb_reg});

    assign in_fire   = in_ch.valid && in_ch.ready;
    assign out_fire  = out_ch.valid && out_ch.ready;
    assign unit_done = (cnt_reg == CW'(XW - 1));
    // restoring division step: remainder shifted with next dividend bit
    assign trial = {acc_reg, opa_reg[XW-1]} - {1'b0, opb_reg};

    // add/sub/mul/div/cmp results only shown after the combine step, unless in error
    assign result_ready = err_reg || (cnt_reg != '0)
        || !(cmd_reg == CMD_ADD || cmd_reg == CMD_SUB || cmd_reg == CMD_MUL
             || cmd_reg == CMD_DIV || cmd_reg == CMD_CMP);

    function automatic logic is_div(state_t s);
        return s == ST_GCD_DIV || s == ST_QA_DIV || s == ST_PA_DIV || s == ST_PB_DIV
            || s == ST_SN_DIV || s == ST_SD_DIV;
    endfunction

    function automatic logic is_mul(state_t s);
        return s == ST_L_MUL || s == ST_PA_MUL || s == ST_PB_MUL
            || s == ST_M1_MUL || s == ST_M2_MUL;
    endfunction

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_fire)
                    state_next = ST_FINISH;
            ST_GCD_STEP:
                if (gy_reg == '0)
                    state_next = (cmd_reg == CMD_SIMP) ? ST_SN_DIV : ST_QA_DIV;
                else
                    state_next = ST_GCD_DIV;
            ST_GCD_DIV:  if (unit_done) state_next = ST_GCD_STEP;
            ST_QA_DIV:   if (unit_done) state_next = ST_L_MUL;
            ST_L_MUL:    if (unit_done) state_next = ST_PA_DIV;
            ST_PA_DIV:   if (unit_done) state_next = ST_PA_MUL;
            ST_PA_MUL:   if (unit_done) state_next = ST_PB_DIV;
            ST_PB_DIV:   if (unit_done) state_next = ST_PB_MUL;
            ST_PB_MUL:   if (unit_done) state_next = ST_OUT;
            ST_M1_MUL:   if (unit_done) state_next = ST_M2_MUL;
            ST_M2_MUL:   if (unit_done) state_next = ST_OUT;
            ST_SN_DIV:   if (unit_done) state_next = ST_SD_DIV;
            ST_SD_DIV:   if (unit_done) state_next = ST_OUT;
            ST_FINISH:
            begin
                if (err_reg)
                    state_next = ST_OUT;
                else
                begin
                    unique case (cmd_reg)
                        CMD_ADD, CMD_SUB, CMD_SIMP: state_next = ST_GCD_STEP;
                        CMD_MUL, CMD_CMP:           state_next = ST_M1_MUL;
                        CMD_DIV:
                            state_next = (nb_reg == '0) ? ST_OUT : ST_M1_MUL;
                        default:                    state_next = ST_OUT;
                    endcase
                end
            end
            ST_OUT:
                if (out_fire)
                    state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs of the handshake
    always_comb
    begin
        in_ch.ready  = (state_reg == ST_IDLE);
        out_ch.valid = (state_reg == ST_OUT) && result_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // datapath
    always_ff @(posedge clk)
    begin
        // serial unit: counter advances in every arithmetic state
        if (is_div(state_reg))
        begin
            opa_reg <= {opa_reg[XW-2:0], 1'b0};
            if (!trial[XW])
            begin
                acc_reg <= trial[XW-1:0];
                quo_reg <= {quo_reg[XW-2:0], 1'b1};
            end
            else
            begin
                acc_reg <= {acc_reg[XW-2:0], opa_reg[XW-1]};
                quo_reg <= {quo_reg[XW-2:0], 1'b0};
            end
            cnt_reg <= unit_done ? '0 : cnt_reg + 1'b1;
        end
        else if (is_mul(state_reg))
        begin
            if (opb_reg[0])
                acc_reg <= acc_reg + opa_reg;
            opa_reg <= {opa_reg[XW-2:0], 1'b0};
            opb_reg <= {1'b0, opb_reg[XW-1:1]};
            cnt_reg <= unit_done ? '0 : cnt_reg + 1'b1;
        end

        unique case (state_reg)
            ST_IDLE:
                if (in_fire)
                begin
                    cmd_reg <= cmd_t'(in_ch.cmd);
                    na_reg  <= in_ch.num_a;
                    nb_reg  <= in_ch.num_b;
                    da_reg  <= in_ch.den_a;
                    db_reg  <= in_ch.den_b;
                    err_reg <= (in_ch.cmd != CMD_NONE) && ((in_ch.den_a == '0)
                        || (in_ch.cmd <= CMD_CMP && in_ch.den_b == '0));
                    cnt_reg <= '0;
                end
            ST_FINISH:
            begin
                gt_reg <= 1'b0;
                lt_reg <= 1'b0;
                eq_reg <= 1'b0;
                rn_reg <= '0;
                rd_reg <= '0;
                acc_reg <= '0;
                if (cmd_reg == CMD_SIMP)
                begin
                    gx_reg <= W'(abs_na);
                    gy_reg <= W'(da_reg);
                end
                else
                begin
                    gx_reg <= W'(da_reg);
                    gy_reg <= W'(db_reg);
                end
                // first multiplication operands
                if (cmd_reg == CMD_DIV || cmd_reg == CMD_CMP)
                begin
                    opa_reg <= abs_na;
                    opb_reg <= XW'(db_reg);
                end
                else
                begin
                    opa_reg <= abs_na;
                    opb_reg <= abs_nb;
                end
                if (!err_reg)
                begin
                    if (cmd_reg == CMD_DIV && nb_reg == '0)
                        err_reg <= 1'b1;
                    if (cmd_reg == CMD_RECIP)
                    begin
                        if (na_reg == '0)
                            err_reg <= 1'b1;
                        rn_reg <= na_reg[W-1] ? -$signed({1'b0, XW'(da_reg)})
                                              : $signed({1'b0, XW'(da_reg)});
                        rd_reg <= abs_na;
                    end
                end
            end
            ST_GCD_STEP:
            begin
                acc_reg <= '0;
                opa_reg <= XW'(gx_reg);
                opb_reg <= XW'(gy_reg);
                // gcd done: prepare next division
                if (gy_reg == '0)
                begin
                    if (cmd_reg == CMD_SIMP)
                    begin
                        if (gx_reg == '0)
                            gx_reg <= W'(1);
                        opa_reg <= abs_na;
                        opb_reg <= (gx_reg == '0) ? XW'(1) : XW'(gx_reg);
                    end
                    else
                    begin
                        opa_reg <= XW'(da_reg);
                        opb_reg <= XW'(gx_reg);
                    end
                end
            end
            ST_GCD_DIV:
                if (unit_done)
                begin
                    gx_reg <= gy_reg;
                    gy_reg <= W'(trial[XW] ? {acc_reg[XW-2:0], opa_reg[XW-1]}
                                           : trial[XW-1:0]);
                end
            default: ;
        endcase

        // transitions between serial operations
        if (unit_done)
        begin
            unique case (state_reg)
                ST_QA_DIV:
                begin
                    acc_reg <= '0;
                    opa_reg <= {quo_reg[XW-2:0], ~trial[XW]};
                    opb_reg <= XW'(db_reg);
                end
                ST_L_MUL:
                begin
                    l_reg   <= acc_reg + (opb_reg[0] ? opa_reg : '0);
                    acc_reg <= '0;
                    opa_reg <= acc_reg + (opb_reg[0] ? opa_reg : '0);
                    opb_reg <= XW'(da_reg);
                end
                ST_PA_DIV:
                begin
                    acc_reg <= '0;
                    opa_reg <= {quo_reg[XW-2:0], ~trial[XW]};
                    opb_reg <= abs_na;
                end
                ST_PA_MUL:
                begin
                    pa_reg  <= acc_reg + (opb_reg[0] ? opa_reg : '0);
                    acc_reg <= '0;
                    opa_reg <= l_reg;
                    opb_reg <= XW'(db_reg);
                end
                ST_PB_DIV:
                begin
                    acc_reg <= '0;
                    opa_reg <= {quo_reg[XW-2:0], ~trial[XW]};
                    opb_reg <= abs_nb;
                end
                ST_PB_MUL:
                begin
                    t_reg <= acc_reg + (opb_reg[0] ? opa_reg : '0);
                    rd_reg <= l_reg;
                end
                ST_M1_MUL:
                begin
                    pa_reg  <= acc_reg + (opb_reg[0] ? opa_reg : '0);
                    acc_reg <= '0;
                    opa_reg <= (cmd_reg == CMD_MUL) ? XW'(da_reg) : abs_nb;
                    opb_reg <= (cmd_reg == CMD_MUL) ? XW'(db_reg) : XW'(da_reg);
                end
                ST_M2_MUL:
                    t_reg <= acc_reg + (opb_reg[0] ? opa_reg : '0);
                ST_SN_DIV:
                begin
                    t_reg   <= {quo_reg[XW-2:0], ~trial[XW]};
                    acc_reg <= '0;
                    opa_reg <= XW'(da_reg);
                    opb_reg <= XW'(gx_reg);
                end
                ST_SD_DIV:
                begin
                    rd_reg <= {quo_reg[XW-2:0], ~trial[XW]};
                    rn_reg <= na_reg[W-1] ? -$signed({1'b0, t_reg}) : $signed({1'b0, t_reg});
                end
                default: ;
            endcase
        end

        // combine signed products into the result once, entering ST_OUT
        if (state_reg == ST_OUT && state_next == ST_OUT && cnt_reg == '0 && !err_reg)
        begin
            cnt_reg <= CW'(1);
            unique case (cmd_reg)
                CMD_ADD, CMD_SUB:
                    rn_reg <= (na_reg[W-1] ? -$signed({1'b0, pa_reg}) : $signed({1'b0, pa_reg}))
                        + (((cmd_reg == CMD_SUB) != nb_reg[W-1])
                           ? -$signed({1'b0, t_reg}) : $signed({1'b0, t_reg}));
                CMD_MUL:
                begin
                    rn_reg <= (na_reg[W-1] != nb_reg[W-1]) ? -$signed({1'b0, pa_reg})
                                                           : $signed({1'b0, pa_reg});
                    rd_reg <= t_reg;
                end
                CMD_DIV:
                begin
                    rn_reg <= (na_reg[W-1] != nb_reg[W-1]) ? -$signed({1'b0, pa_reg})
                                                           : $signed({1'b0, pa_reg});
                    rd_reg <= t_reg;
                end
                CMD_CMP:
                begin
                    // signed cross products x = na*db, y = nb*da
                    gt_reg <= (na_reg[W-1] ? -$signed({1'b0, pa_reg}) : $signed({1'b0, pa_reg}))
                            > (nb_reg[W-1] ? -$signed({1'b0, t_reg}) : $signed({1'b0, t_reg}));
                    lt_reg <= (na_reg[W-1] ? -$signed({1'b0, pa_reg}) : $signed({1'b0, pa_reg}))
                            < (nb_reg[W-1] ? -$signed({1'b0, t_reg}) : $signed({1'b0, t_reg}));
                    eq_reg <= (na_reg[W-1] ? -$signed({1'b0, pa_reg}) : $signed({1'b0, pa_reg}))
                           == (nb_reg[W-1] ? -$signed({1'b0, t_reg}) : $signed({1'b0, t_reg}));
                end
                default: ;
            endcase
        end
        else if (out_fire)
            cnt_reg <= '0;
    end

    // results widened so the 32-bit limits compare correctly at any operand width
    assign rn_wide = SW'(rn_reg);
    assign rd_wide = SW'(rd_reg);

    // output packing with saturation
    always_comb
    begin
        out_ch.greater        = gt_reg && !err_reg && result_ready;
        out_ch.less           = lt_reg && !err_reg && result_ready;
        out_ch.equal          = eq_reg && !err_reg && result_ready;
        out_ch.zero_den_error = err_reg;
        if (err_reg || cmd_reg == CMD_CMP || cmd_reg == CMD_NONE || !result_ready)
        begin
            out_ch.res_num = '0;
            out_ch.res_den = '0;
        end
        else
        begin
            if (rn_wide > $signed(SW'(33'sh07fffffff)))
                out_ch.res_num = 32'sh7fffffff;
            else if (rn_wide < -$signed(SW'(33'sh080000000)))
                out_ch.res_num = 32'sh80000000;
            else
                out_ch.res_num = ResNumWidth'(rn_wide);
            if (rd_wide > SW'(32'h7fffffff))
                out_ch.res_den = 31'h7fffffff;
            else
                out_ch.res_den = ResDenWidth'(rd_wide);
        end
    end

endmodule

[rtl/rau_checker.sv]
module rau_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic zero_den_error,
    input logic greater,
    input logic less,
    input logic equal
);
    import rau_pkg::*;

    // never accept an item while a result waits
    assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> !in_ready)
        else $error("input accepted while result pending");
    // result held until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped");
    // at most one compare flag
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $onehot0({greater, less, equal}))
        else $error("compare flags conflict");
    // error clears compare flags
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_den_error |-> !(greater || less || equal))
        else $error("flags with error");
endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .zero_den_error (out_ch.zero_den_error),
    .greater        (out_ch.greater),
    .less           (out_ch.less),
    .equal          (out_ch.equal)
);
